@@ hw/rtl/jvs_pkg.sv @@
// ----------------------------------------------------------------------------
// jvs_pkg
// Shared types, constants and helper functions of the JSON value skipper.
// ----------------------------------------------------------------------------
package jvs_pkg;

	localparam int MAX_DEPTH = 32;
	localparam int DEPTH_W   = $clog2(MAX_DEPTH + 1);
	localparam int IDX_W     = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

	typedef enum logic [3:0] {
		M_IDLE,
		M_FIRST,
		M_VALUE,
		M_NEXT,
		M_COLON,
		M_STR,
		M_ESC,
		M_LIT,
		M_INT,
		M_FRAC,
		M_ESIGN,
		M_EXP
	} mode_t;

	typedef enum logic [1:0] {
		K_ARRAY,
		K_KEY,
		K_VAL
	} kind_t;

	typedef enum logic [1:0] {
		ERR_NONE,
		ERR_BYTE,
		ERR_EOD,
		ERR_DEEP
	} err_t;

	localparam logic [1:0] LIT_TRUE  = 2'd0;
	localparam logic [1:0] LIT_FALSE = 2'd1;
	localparam logic [1:0] LIT_NULL  = 2'd2;

	localparam logic [7:0] CH_SP     = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_0      = 8'h30;
	localparam logic [7:0] CH_9      = 8'h39;
	localparam logic [7:0] CH_LO_E   = 8'h65;
	localparam logic [7:0] CH_UP_E   = 8'h45;
	localparam logic [7:0] CH_LO_T   = 8'h74;
	localparam logic [7:0] CH_LO_F   = 8'h66;
	localparam logic [7:0] CH_LO_N   = 8'h6E;

	typedef struct packed {
		mode_t              mode;
		logic [1:0]         lit_word;
		logic [2:0]         lit_idx;
		logic [DEPTH_W-1:0] depth;
		err_t               err;
		kind_t              top;
	} pstate_t;

	localparam pstate_t PSTATE_RESET = '{
		mode:     M_IDLE,
		lit_word: 2'd0,
		lit_idx:  3'd0,
		depth:    '0,
		err:      ERR_NONE,
		top:      K_ARRAY
	};

	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] addr;
		kind_t            data;
	} stk_wr_t;

	typedef struct packed {
		logic       inside_value;
		logic [5:0] nest_depth;
		err_t       error_kind;
		logic       value_done;
	} result_t;

	function automatic logic is_num_mode(input mode_t m);
		return (m == M_INT) || (m == M_FRAC) || (m == M_ESIGN) || (m == M_EXP);
	endfunction

	// Expected byte of a literal at a given position.
	function automatic logic [7:0] lit_char(input logic [1:0] word, input logic [2:0] idx);
		logic [7:0] c;
		c = 8'h00;
		case (word)
			LIT_TRUE: begin
				case (idx)
					3'd0:    c = "t";
					3'd1:    c = "r";
					3'd2:    c = "u";
					3'd3:    c = "e";
					default: c = 8'h00;
				endcase
			end
			LIT_FALSE: begin
				case (idx)
					3'd0:    c = "f";
					3'd1:    c = "a";
					3'd2:    c = "l";
					3'd3:    c = "s";
					3'd4:    c = "e";
					default: c = 8'h00;
				endcase
			end
			LIT_NULL: begin
				case (idx)
					3'd0:    c = "n";
					3'd1:    c = "u";
					3'd2:    c = "l";
					3'd3:    c = "l";
					default: c = 8'h00;
				endcase
			end
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic [2:0] lit_len(input logic [1:0] word);
		return (word == LIT_FALSE) ? 3'd5 : 3'd4;
	endfunction

endpackage

@@ hw/rtl/jvs_stack.sv @@
// ----------------------------------------------------------------------------
// jvs_stack
// Container kind memory: one write port, one registered read port that
// prefetches the entry below the top for the next byte.
// ----------------------------------------------------------------------------
module jvs_stack
	import jvs_pkg::*;
(
	input  logic             clk,
	input  stk_wr_t          wr,
	input  logic             re,
	input  logic [IDX_W-1:0] raddr,
	output kind_t            rdata
);

	kind_t mem [MAX_DEPTH];

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem[wr.addr] <= wr.data;
		end
	end

	// The write address is always the new top, never the entry below it,
	// so the old contents are the right ones to read here.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ hw/rtl/jvs_step.sv @@
// ----------------------------------------------------------------------------
// jvs_step
// Per-byte parser update: next state, stack write and result for one byte.
// ----------------------------------------------------------------------------
module jvs_step
	import jvs_pkg::*;
(
	input  pstate_t    cur,
	input  kind_t      below,
	input  logic [7:0] data_byte,
	input  logic       end_of_data,
	output pstate_t    nxt_st,
	output stk_wr_t    wr,
	output result_t    res
);

	pstate_t            nxt;
	kind_t              top_eff;
	kind_t              top_nxt;
	kind_t              set_kind;
	kind_t              push_kind;
	mode_t              m1;
	logic [7:0]         close_ch;
	logic [DEPTH_W-1:0] depth_dec;
	logic [2:0]         idx_inc;
	logic               ws;
	logic               digit;
	logic               num_cont;
	logic               start_v;
	logic               close_v;
	logic               fin_v;
	logic               set_v;
	logic               bad;
	logic               done;

	always_comb begin
		nxt       = cur;
		wr        = '{we: 1'b0, addr: '0, data: K_ARRAY};
		done      = 1'b0;
		num_cont  = 1'b0;
		start_v   = 1'b0;
		close_v   = 1'b0;
		fin_v     = 1'b0;
		set_v     = 1'b0;
		bad       = 1'b0;
		set_kind  = K_ARRAY;
		push_kind = K_ARRAY;
		m1        = cur.mode;
		top_eff   = (cur.depth == '0) ? K_ARRAY : cur.top;
		close_ch  = (top_eff == K_ARRAY) ? CH_RBRACK : CH_RBRACE;
		ws        = data_byte inside {CH_SP, CH_TAB, CH_LF, CH_CR};
		digit     = data_byte inside {[CH_0:CH_9]};
		depth_dec = cur.depth - DEPTH_W'(1);
		idx_inc   = cur.lit_idx + 3'd1;
		top_nxt   = K_ARRAY;

		if (cur.err == ERR_NONE) begin
			// stay inside a number while the byte fits its syntax
			case (cur.mode)
				M_INT: begin
					if (digit) begin
						num_cont = 1'b1;
					end else if (data_byte == CH_DOT) begin
						num_cont = 1'b1;
						nxt.mode = M_FRAC;
					end else if (data_byte == CH_LO_E || data_byte == CH_UP_E) begin
						num_cont = 1'b1;
						nxt.mode = M_ESIGN;
					end
				end
				M_FRAC: begin
					if (digit) begin
						num_cont = 1'b1;
					end else if (data_byte == CH_LO_E || data_byte == CH_UP_E) begin
						num_cont = 1'b1;
						nxt.mode = M_ESIGN;
					end
				end
				M_ESIGN: begin
					if (digit || data_byte == CH_PLUS || data_byte == CH_MINUS) begin
						num_cont = 1'b1;
						nxt.mode = M_EXP;
					end
				end
				M_EXP: begin
					num_cont = digit;
				end
				default: ;
			endcase

			if (!num_cont) begin
				// a number ended: complete it, then handle the byte again
				if (is_num_mode(cur.mode)) begin
					if (cur.depth == '0) begin
						m1   = M_IDLE;
						done = 1'b1;
					end else begin
						m1 = (top_eff == K_KEY) ? M_COLON : M_NEXT;
					end
				end
				nxt.mode = m1;

				case (m1)
					M_IDLE, M_VALUE: begin
						start_v = !ws;
					end
					M_FIRST: begin
						if (!ws) begin
							if (data_byte == close_ch) close_v = 1'b1;
							else                       start_v = 1'b1;
						end
					end
					M_NEXT: begin
						if (!ws) begin
							if (data_byte == close_ch) begin
								close_v = 1'b1;
							end else if (data_byte == CH_COMMA) begin
								if (top_eff != K_ARRAY) begin
									set_v    = 1'b1;
									set_kind = K_KEY;
								end
								nxt.mode = M_VALUE;
							end else begin
								bad = 1'b1;
							end
						end
					end
					M_COLON: begin
						if (!ws) begin
							if (data_byte == CH_COLON) begin
								set_v    = 1'b1;
								set_kind = K_VAL;
								nxt.mode = M_VALUE;
							end else begin
								bad = 1'b1;
							end
						end
					end
					M_STR: begin
						if (data_byte == CH_BSLASH)     nxt.mode = M_ESC;
						else if (data_byte == CH_QUOTE) fin_v = 1'b1;
					end
					M_ESC: begin
						nxt.mode = M_STR;
					end
					M_LIT: begin
						if (cur.lit_word > LIT_NULL || cur.lit_idx >= 3'd5 ||
						    data_byte != lit_char(cur.lit_word, cur.lit_idx)) begin
							bad = 1'b1;
						end else begin
							nxt.lit_idx = idx_inc;
							fin_v       = (idx_inc >= lit_len(cur.lit_word));
						end
					end
					default: begin
						bad = 1'b1;
					end
				endcase

				if (start_v) begin
					if (data_byte == CH_QUOTE) begin
						nxt.mode = M_STR;
					end else if (data_byte == CH_LBRACK || data_byte == CH_LBRACE) begin
						push_kind = (data_byte == CH_LBRACK) ? K_ARRAY : K_KEY;
						if (cur.depth >= DEPTH_W'(MAX_DEPTH)) begin
							nxt.err = ERR_DEEP;
						end else begin
							wr.we     = 1'b1;
							wr.addr   = cur.depth[IDX_W-1:0];
							wr.data   = push_kind;
							nxt.depth = cur.depth + DEPTH_W'(1);
							nxt.top   = push_kind;
							nxt.mode  = M_FIRST;
						end
					end else if (data_byte == CH_LO_T || data_byte == CH_LO_F ||
					             data_byte == CH_LO_N) begin
						nxt.lit_word = (data_byte == CH_LO_T) ? LIT_TRUE :
						               (data_byte == CH_LO_F) ? LIT_FALSE : LIT_NULL;
						nxt.lit_idx  = 3'd1;
						nxt.mode     = M_LIT;
					end else if (digit || data_byte == CH_MINUS) begin
						nxt.mode = M_INT;
					end else begin
						bad = 1'b1;
					end
				end

				if (close_v) begin
					if (cur.depth == '0) begin
						bad = 1'b1;
					end else begin
						nxt.depth = depth_dec;
						if (depth_dec == '0) begin
							nxt.mode = M_IDLE;
							done     = 1'b1;
						end else begin
							nxt.top  = below;
							nxt.mode = (below == K_KEY) ? M_COLON : M_NEXT;
						end
					end
				end

				if (fin_v) begin
					if (cur.depth == '0) begin
						nxt.mode = M_IDLE;
						done     = 1'b1;
					end else begin
						nxt.mode = (top_eff == K_KEY) ? M_COLON : M_NEXT;
					end
				end

				if (set_v && cur.depth != '0) begin
					wr.we   = 1'b1;
					wr.addr = depth_dec[IDX_W-1:0];
					wr.data = set_kind;
					nxt.top = set_kind;
				end

				if (bad) begin
					nxt.err = ERR_BYTE;
				end
			end
		end

		// end of buffer: close an open number, then flag an open value
		if (end_of_data && nxt.err == ERR_NONE) begin
			top_nxt = (nxt.depth == '0) ? K_ARRAY : nxt.top;
			if (is_num_mode(nxt.mode)) begin
				if (nxt.depth == '0) begin
					nxt.mode = M_IDLE;
					done     = 1'b1;
				end else begin
					nxt.mode = (top_nxt == K_KEY) ? M_COLON : M_NEXT;
				end
			end
			if (nxt.mode != M_IDLE) begin
				nxt.err = ERR_EOD;
			end
		end

		res.value_done   = done;
		res.error_kind   = nxt.err;
		res.nest_depth   = 6'(nxt.depth);
		res.inside_value = (nxt.mode != M_IDLE);

		nxt_st = end_of_data ? PSTATE_RESET : nxt;
	end

endmodule

@@ hw/rtl/json_value_skipper_top.sv @@
// ----------------------------------------------------------------------------
// json_value_skipper_top
// Streaming JSON value skipper: one byte in, one status result out.
// ----------------------------------------------------------------------------
// Path from byte acceptance to result valid: the input register, then the
// parser update into the result register.
// Throughput: one byte per cycle while the result register is free or m_tready
// is high; the parser state and the stack update together for each byte.
// Reset: arst_n clears the parser state and both valid flags at once; the
// container stack holds no reset value and needs no clearing pass.
module json_value_skipper_top
	import jvs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tlast,   // end_of_data
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // [0] value_done, [2:1] error_kind,
	                               // [8:3] nest_depth, [9] inside_value
);

	logic               valid_s1;
	logic [7:0]         byte_s1;
	logic               eod_s1;
	logic               out_valid_q;
	result_t            res_q;
	result_t            res_d;
	pstate_t            state_q;
	pstate_t            state_d;
	stk_wr_t            wr_d;
	stk_wr_t            wr_gated;
	kind_t              below;
	logic [DEPTH_W-1:0] below_addr;
	logic               advance;

	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			eod_s1  <= s_tlast;
		end
	end

	jvs_step u_step (
		.cur         (state_q),
		.below       (below),
		.data_byte   (byte_s1),
		.end_of_data (eod_s1),
		.nxt_st      (state_d),
		.wr          (wr_d),
		.res         (res_d)
	);

	// prefetch the entry below the next top
	assign below_addr = state_d.depth - DEPTH_W'(2);

	always_comb begin
		wr_gated    = wr_d;
		wr_gated.we = wr_d.we && advance;
	end

	jvs_stack u_stack (
		.clk   (clk),
		.wr    (wr_gated),
		.re    (advance),
		.raddr (below_addr[IDX_W-1:0]),
		.rdata (below)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= PSTATE_RESET;
		end else if (advance) begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, res_q};

	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.depth <= DEPTH_W'(MAX_DEPTH))
		else $error("nesting depth beyond stack size");

	a_error_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.err != ERR_NONE && advance && !eod_s1) |=>
		(state_q.err == $past(state_q.err) && state_q.depth == $past(state_q.depth) &&
		 state_q.mode == $past(state_q.mode)))
		else $error("parser state moved while an error was latched");

	a_eod_reset: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && eod_s1) |=>
		(state_q.mode == M_IDLE && state_q.depth == '0 && state_q.err == ERR_NONE))
		else $error("parser state not cleared after end of data");

	// a number closed by an opening bracket completes at depth 0 and opens depth 1
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && res_d.value_done && res_d.error_kind == ERR_NONE) |->
		(res_d.nest_depth <= 6'd1))
		else $error("value completion reported inside a container");

endmodule
